// ===== hw/rtl/obrd_pkg.sv =====
// ---------------------------------------------------------------------------
// Oversampled bit-run decoder package
// Widths, character table, microcode word layout and control program.
// ---------------------------------------------------------------------------
`default_nettype none

package obrd_pkg;

   localparam int RunWidth      = 16;
   localparam int MaxBitsPerRun = 256;
   localparam int RepWidth      = 8;
   localparam int DenWidth      = RepWidth + 1;
   localparam int RemWidth      = DenWidth + 1;
   localparam int NumWidth      = RunWidth + 2;
   localparam int DivCntWidth   = $clog2(NumWidth + 1);
   localparam int BitCntWidth   = $clog2(MaxBitsPerRun + 1);
   localparam int TableLen      = 58;
   localparam int IdxWidth      = $clog2(TableLen);
   localparam int DistWidth     = 4;
   localparam int StepWidth     = 5;

   localparam logic [7:0] FallbackChar = 8'h3F;
   localparam logic [DistWidth-1:0] NoMatchDist = DistWidth'(8);

   // program labels
   localparam logic [StepWidth-1:0] StepIdle      = 5'd0;
   localparam logic [StepWidth-1:0] StepCheck     = 5'd1;
   localparam logic [StepWidth-1:0] StepADivInit  = 5'd2;
   localparam logic [StepWidth-1:0] StepADivStep  = 5'd3;
   localparam logic [StepWidth-1:0] StepACap      = 5'd4;
   localparam logic [StepWidth-1:0] StepATest     = 5'd5;
   localparam logic [StepWidth-1:0] StepAEmit     = 5'd6;
   localparam logic [StepWidth-1:0] StepAScanInit = 5'd7;
   localparam logic [StepWidth-1:0] StepAScan     = 5'd8;
   localparam logic [StepWidth-1:0] StepAPush     = 5'd9;
   localparam logic [StepWidth-1:0] StepUpdate    = 5'd10;
   localparam logic [StepWidth-1:0] StepBDivInit  = 5'd11;
   localparam logic [StepWidth-1:0] StepBDivStep  = 5'd12;
   localparam logic [StepWidth-1:0] StepBCap      = 5'd13;
   localparam logic [StepWidth-1:0] StepBTest     = 5'd14;
   localparam logic [StepWidth-1:0] StepBEmit     = 5'd15;
   localparam logic [StepWidth-1:0] StepBScanInit = 5'd16;
   localparam logic [StepWidth-1:0] StepBScan     = 5'd17;
   localparam logic [StepWidth-1:0] StepBPush     = 5'd18;
   localparam logic [StepWidth-1:0] StepClear     = 5'd19;
   localparam logic [StepWidth-1:0] StepFinish    = 5'd20;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_CAP,
      OP_EMIT,
      OP_SCAN_INIT,
      OP_SCAN,
      OP_PUSH,
      OP_UPDATE,
      OP_CLEAR,
      OP_FINISH
   } op_type;

   typedef enum logic [3:0] {
      JC_NEXT,
      JC_ALWAYS,
      JC_NO_REQ,
      JC_NO_CLOSE,
      JC_DIV_BUSY,
      JC_BITS_ZERO,
      JC_BYTE_OPEN,
      JC_SCAN_BUSY,
      JC_NOT_END
   } jump_type;

   typedef struct packed {
      op_type                 op;
      jump_type               cond;
      logic                   wait_out;
      logic [StepWidth-1:0]   target;
   } uword_type;

   function automatic uword_type ucode(input logic [StepWidth-1:0] step);
      uword_type w;
      w = '{op: OP_NOP, cond: JC_ALWAYS, wait_out: 1'b0, target: StepIdle};
      case (step)
         StepIdle:      w = '{OP_ACCEPT,    JC_NO_REQ,    1'b0, StepIdle};
         StepCheck:     w = '{OP_NOP,       JC_NO_CLOSE,  1'b0, StepUpdate};
         StepADivInit:  w = '{OP_DIV_INIT,  JC_NEXT,      1'b0, StepIdle};
         StepADivStep:  w = '{OP_DIV_STEP,  JC_DIV_BUSY,  1'b0, StepADivStep};
         StepACap:      w = '{OP_CAP,       JC_NEXT,      1'b0, StepIdle};
         StepATest:     w = '{OP_NOP,       JC_BITS_ZERO, 1'b0, StepUpdate};
         StepAEmit:     w = '{OP_EMIT,      JC_BYTE_OPEN, 1'b0, StepATest};
         StepAScanInit: w = '{OP_SCAN_INIT, JC_NEXT,      1'b0, StepIdle};
         StepAScan:     w = '{OP_SCAN,      JC_SCAN_BUSY, 1'b0, StepAScan};
         StepAPush:     w = '{OP_PUSH,      JC_ALWAYS,    1'b1, StepATest};
         StepUpdate:    w = '{OP_UPDATE,    JC_NOT_END,   1'b0, StepFinish};
         StepBDivInit:  w = '{OP_DIV_INIT,  JC_NEXT,      1'b0, StepIdle};
         StepBDivStep:  w = '{OP_DIV_STEP,  JC_DIV_BUSY,  1'b0, StepBDivStep};
         StepBCap:      w = '{OP_CAP,       JC_NEXT,      1'b0, StepIdle};
         StepBTest:     w = '{OP_NOP,       JC_BITS_ZERO, 1'b0, StepClear};
         StepBEmit:     w = '{OP_EMIT,      JC_BYTE_OPEN, 1'b0, StepBTest};
         StepBScanInit: w = '{OP_SCAN_INIT, JC_NEXT,      1'b0, StepIdle};
         StepBScan:     w = '{OP_SCAN,      JC_SCAN_BUSY, 1'b0, StepBScan};
         StepBPush:     w = '{OP_PUSH,      JC_ALWAYS,    1'b1, StepBTest};
         StepClear:     w = '{OP_CLEAR,     JC_NEXT,      1'b0, StepIdle};
         StepFinish:    w = '{OP_FINISH,    JC_ALWAYS,    1'b1, StepIdle};
         default:       w = '{OP_NOP,       JC_ALWAYS,    1'b0, StepIdle};
      endcase
      return w;
   endfunction

   // valid characters in search order; zero byte is valid but never a match
   function automatic logic [7:0] valid_char(input logic [IdxWidth-1:0] idx);
      logic [7:0] c;
      c = FallbackChar;
      case (idx) inside
         [6'd0:6'd25]:  c = 8'h41 + {2'b00, idx};
         [6'd26:6'd51]: c = 8'h61 + {2'b00, idx} - 8'd26;
         6'd52:         c = 8'h20;
         6'd53:         c = 8'h3A;
         6'd54:         c = 8'h2E;
         6'd55:         c = 8'h2C;
         6'd56:         c = 8'h0A;
         6'd57:         c = 8'h27;
         default:       c = FallbackChar;
      endcase
      return c;
   endfunction

   function automatic logic [DistWidth-1:0] popcount8(input logic [7:0] x);
      logic [DistWidth-1:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + DistWidth'(x[i]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/oversampled_bit_run_decoder_core.sv =====
// ---------------------------------------------------------------------------
// Oversampled bit-run decoder core
// Measures runs of equal samples, recovers bits, packs and corrects bytes.
// ---------------------------------------------------------------------------
// Usage: each req item carries one channel sample and an end marker. A closed
// run yields round(run/repeat_count) bits (capped at 256 per item), packed
// LSB first into bytes; each byte comes out on rsp as a corrected character,
// last_of_run set on the final character of the item. csr writes repeat_count
// and is always ready; write it only while the block is idle.
// Sequencing: a microcoded sequencer runs one item at a time. Each closed run
// goes through an 18-step divider and setup, then emits its recovered bits one
// by one; each completed byte runs the 58-entry nearest-character scan. An
// end marker adds the second run close and a clear step.
// Characters pass through a one-deep hold and an output register; the
// sequencer stalls only when both are full and rsp_ready is low.
// Reset: run state, byte packing and outputs clear; repeat_count becomes 1.
// ---------------------------------------------------------------------------
`default_nettype none

module oversampled_bit_run_decoder_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_sample_bit,
   input  wire logic       req_end_of_stream,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_char_out,
   output logic            rsp_was_corrected,
   output logic            rsp_last_of_run,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_repeat_count
);

   localparam int RW = obrd_pkg::RunWidth;
   localparam int NW = obrd_pkg::NumWidth;
   localparam int BW = obrd_pkg::BitCntWidth;
   localparam int DW = obrd_pkg::DenWidth;
   localparam int MW = obrd_pkg::RemWidth;
   localparam int CW = obrd_pkg::DivCntWidth;
   localparam int IW = obrd_pkg::IdxWidth;
   localparam int PW = obrd_pkg::DistWidth;
   localparam int SW = obrd_pkg::StepWidth;

   logic [SW-1:0]  step_ff, step_in;
   logic [7:0]     repeat_ff, repeat_in;
   logic           sample_ff, sample_in;
   logic           end_ff, end_in;
   logic           run_bit_ff, run_bit_in;
   logic [RW-1:0]  run_len_ff, run_len_in;
   logic [7:0]     byte_ff, byte_in;
   logic [2:0]     bib_ff, bib_in;
   logic [BW-1:0]  budget_ff, budget_in;
   logic [BW-1:0]  bits_ff, bits_in;
   logic [NW-1:0]  div_num_ff, div_num_in;
   logic [MW-1:0]  rem_ff, rem_in;
   logic [CW-1:0]  div_cnt_ff, div_cnt_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [7:0]     best_ff, best_in;
   logic [PW-1:0]  bestd_ff, bestd_in;
   logic           hold_valid_ff, hold_valid_in;
   logic [7:0]     hold_char_ff, hold_char_in;
   logic           hold_corr_ff, hold_corr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_char_ff, rsp_char_in;
   logic           rsp_corr_ff, rsp_corr_in;
   logic           rsp_last_ff, rsp_last_in;

   obrd_pkg::uword_type uw;
   logic           out_blocked;
   logic           stall;
   logic           taken;
   logic           close_needed;
   logic [7:0]     rep_eff;
   logic [DW-1:0]  den;
   logic [MW-1:0]  trial;
   logic           trial_ge;
   logic [BW-1:0]  cap_bits;
   logic [BW-1:0]  take_bits;
   logic [7:0]     cand;
   logic [PW-1:0]  cand_d;

   assign uw           = obrd_pkg::ucode(step_ff);
   assign out_blocked  = hold_valid_ff && rsp_valid_ff && !rsp_ready;
   assign stall        = uw.wait_out && out_blocked;
   assign close_needed = (run_len_ff != '0) && (sample_ff != run_bit_ff);

   assign rep_eff  = (repeat_ff == 8'd0) ? 8'd1 : repeat_ff;
   assign den      = {rep_eff, 1'b0};
   assign trial    = {rem_ff[MW-2:0], div_num_ff[NW-1]};
   assign trial_ge = (trial >= {1'b0, den});

   assign cap_bits  = (div_num_ff > NW'(obrd_pkg::MaxBitsPerRun)) ?
                      BW'(obrd_pkg::MaxBitsPerRun) : div_num_ff[BW-1:0];
   assign take_bits = (cap_bits > budget_ff) ? budget_ff : cap_bits;

   assign cand   = obrd_pkg::valid_char(idx_ff);
   assign cand_d = obrd_pkg::popcount8(byte_ff ^ cand);

   always_comb begin
      case (uw.cond)
         obrd_pkg::JC_NEXT:      taken = 1'b0;
         obrd_pkg::JC_ALWAYS:    taken = 1'b1;
         obrd_pkg::JC_NO_REQ:    taken = !req_valid;
         obrd_pkg::JC_NO_CLOSE:  taken = !close_needed;
         obrd_pkg::JC_DIV_BUSY:  taken = (div_cnt_ff != CW'(1));
         obrd_pkg::JC_BITS_ZERO: taken = (bits_ff == '0);
         obrd_pkg::JC_BYTE_OPEN: taken = (bib_ff != 3'd7);
         obrd_pkg::JC_SCAN_BUSY: taken = (idx_ff != IW'(obrd_pkg::TableLen - 1));
         obrd_pkg::JC_NOT_END:   taken = !end_ff;
         default:                taken = 1'b0;
      endcase
   end

   always_comb begin
      if (stall) begin
         step_in = step_ff;
      end else if (taken) begin
         step_in = uw.target;
      end else begin
         step_in = step_ff + SW'(1);
      end
   end

   always_comb begin
      repeat_in     = repeat_ff;
      sample_in     = sample_ff;
      end_in        = end_ff;
      run_bit_in    = run_bit_ff;
      run_len_in    = run_len_ff;
      byte_in       = byte_ff;
      bib_in        = bib_ff;
      budget_in     = budget_ff;
      bits_in       = bits_ff;
      div_num_in    = div_num_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      idx_in        = idx_ff;
      best_in       = best_ff;
      bestd_in      = bestd_ff;
      hold_valid_in = hold_valid_ff;
      hold_char_in  = hold_char_ff;
      hold_corr_in  = hold_corr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_char_in   = rsp_char_ff;
      rsp_corr_in   = rsp_corr_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_valid) begin
         repeat_in = csr_repeat_count;
      end

      if (!stall) begin
         case (uw.op)
            obrd_pkg::OP_ACCEPT: begin
               if (req_valid) begin
                  sample_in = req_sample_bit;
                  end_in    = req_end_of_stream;
                  budget_in = BW'(obrd_pkg::MaxBitsPerRun);
               end
            end
            obrd_pkg::OP_DIV_INIT: begin
               div_num_in = {run_len_ff, 1'b0} + NW'(rep_eff);
               rem_in     = '0;
               div_cnt_in = CW'(NW);
            end
            obrd_pkg::OP_DIV_STEP: begin
               rem_in     = trial_ge ? (trial - {1'b0, den}) : trial;
               div_num_in = {div_num_ff[NW-2:0], trial_ge};
               div_cnt_in = div_cnt_ff - CW'(1);
            end
            obrd_pkg::OP_CAP: begin
               bits_in    = take_bits;
               budget_in  = budget_ff - take_bits;
               run_len_in = '0;
            end
            obrd_pkg::OP_EMIT: begin
               byte_in[bib_ff] = run_bit_ff;
               bib_in          = bib_ff + 3'd1;
               bits_in         = bits_ff - BW'(1);
            end
            obrd_pkg::OP_SCAN_INIT: begin
               idx_in   = '0;
               best_in  = obrd_pkg::FallbackChar;
               bestd_in = obrd_pkg::NoMatchDist;
            end
            obrd_pkg::OP_SCAN: begin
               if (cand_d < bestd_ff) begin
                  bestd_in = cand_d;
                  best_in  = cand;
               end
               if (idx_ff != IW'(obrd_pkg::TableLen - 1)) begin
                  idx_in = idx_ff + IW'(1);
               end
            end
            obrd_pkg::OP_PUSH: begin
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = hold_char_ff;
                  rsp_corr_in  = hold_corr_ff;
                  rsp_last_in  = 1'b0;
               end
               hold_valid_in = 1'b1;
               hold_char_in  = (byte_ff == 8'd0) ? 8'd0 : best_ff;
               hold_corr_in  = !((byte_ff == 8'd0) || (bestd_ff == '0));
               byte_in       = '0;
               bib_in        = '0;
            end
            obrd_pkg::OP_UPDATE: begin
               if (run_len_ff == '0) begin
                  run_bit_in = sample_ff;
                  run_len_in = RW'(1);
               end else if (run_len_ff != '1) begin
                  run_len_in = run_len_ff + RW'(1);
               end
            end
            obrd_pkg::OP_CLEAR: begin
               run_bit_in = 1'b0;
               run_len_in = '0;
               byte_in    = '0;
               bib_in     = '0;
            end
            obrd_pkg::OP_FINISH: begin
               if (hold_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_char_in   = hold_char_ff;
                  rsp_corr_in   = hold_corr_ff;
                  rsp_last_in   = 1'b1;
                  hold_valid_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= obrd_pkg::StepIdle;
         repeat_ff     <= 8'd1;
         run_bit_ff    <= 1'b0;
         run_len_ff    <= '0;
         byte_ff       <= '0;
         bib_ff        <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         repeat_ff     <= repeat_in;
         run_bit_ff    <= run_bit_in;
         run_len_ff    <= run_len_in;
         byte_ff       <= byte_in;
         bib_ff        <= bib_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      end_ff       <= end_in;
      budget_ff    <= budget_in;
      bits_ff      <= bits_in;
      div_num_ff   <= div_num_in;
      rem_ff       <= rem_in;
      div_cnt_ff   <= div_cnt_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      bestd_ff     <= bestd_in;
      hold_char_ff <= hold_char_in;
      hold_corr_ff <= hold_corr_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_corr_ff  <= rsp_corr_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready         = (uw.op == obrd_pkg::OP_ACCEPT);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_char_out      = rsp_char_ff;
   assign rsp_was_corrected = rsp_corr_ff;
   assign rsp_last_of_run   = rsp_last_ff;

endmodule

`default_nettype wire
